[sv/ssfc_pkg.sv]
package ssfc_pkg;

  localparam int DEF_ENTRIES = 8;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 6;

  typedef struct packed {
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  destination_address;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  destination_port;
    logic [PROTO_W-1:0] protocol;
  } key_t;

  // one table row as held in the RAM
  typedef struct packed {
    key_t               key;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] ovr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               matched;
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] error_bound;
  } res_t;

endpackage

[sv/ssfc_if.sv]
interface ssfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssfc_pkg::ADDR_W-1:0]  source_address;
  logic [ssfc_pkg::ADDR_W-1:0]  destination_address;
  logic [ssfc_pkg::PORT_W-1:0]  source_port;
  logic [ssfc_pkg::PORT_W-1:0]  destination_port;
  logic [ssfc_pkg::PROTO_W-1:0] protocol;

  modport source (output valid, source_address, destination_address, source_port,
                  destination_port, protocol, input ready);
  modport sink   (input valid, source_address, destination_address, source_port,
                  destination_port, protocol, output ready);
endinterface

interface ssfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssfc_pkg::SLOT_W-1:0]  slot;
  logic                        matched;
  logic [ssfc_pkg::COUNT_W-1:0] new_count;
  logic [ssfc_pkg::COUNT_W-1:0] error_bound;

  modport source (output valid, slot, matched, new_count, error_bound, input ready);
  modport sink   (input valid, slot, matched, new_count, error_bound, output ready);
endinterface

[sv/ssfc_ram.sv]
module ssfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ssfc_scan.sv]
module ssfc_scan #(
  parameter int NUM_ENTRIES = ssfc_pkg::DEF_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ssfc_in_if.sink                        in_chan,
  input  logic                           res_ready,
  output logic                           res_push,
  output ssfc_pkg::res_t                 res,
  output logic                           ram_we,
  output logic [$clog2(NUM_ENTRIES)-1:0] ram_waddr,
  output ssfc_pkg::entry_t               ram_wdata,
  output logic [$clog2(NUM_ENTRIES)-1:0] ram_raddr,
  input  ssfc_pkg::entry_t               ram_rdata
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                       state_r;
  ssfc_pkg::key_t               key_r;
  logic [CW-1:0]                iss_r;
  logic                         dv_r;
  logic [IW-1:0]                didx_r;
  logic [NUM_ENTRIES-1:0]       vld_r;
  logic                         found_r;
  logic [IW-1:0]                hit_r;
  logic [ssfc_pkg::COUNT_W-1:0] hit_cnt_r;
  logic [ssfc_pkg::COUNT_W-1:0] hit_ovr_r;
  logic [ssfc_pkg::COUNT_W-1:0] least_r;
  logic [IW-1:0]                victim_r;

  ssfc_pkg::entry_t             ent;
  ssfc_pkg::key_t               in_key;
  logic                         accept;
  logic                         issue;
  logic                         hit_now;
  logic [ssfc_pkg::COUNT_W-1:0] wr_count;
  logic [ssfc_pkg::COUNT_W-1:0] wr_ovr;

  assign in_key = '{source_address:      in_chan.source_address,
                    destination_address: in_chan.destination_address,
                    source_port:         in_chan.source_port,
                    destination_port:    in_chan.destination_port,
                    protocol:            in_chan.protocol};

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign issue         = (state_r == ST_SCAN) && (iss_r != CW'(NUM_ENTRIES));
  assign ram_raddr     = iss_r[IW-1:0];

  // entries never written read as all zero
  assign ent     = vld_r[didx_r] ? ram_rdata : '0;
  assign hit_now = (ent.key == key_r);

  assign res_push  = (state_r == ST_WRITE) && res_ready;
  assign wr_count  = found_r ? hit_cnt_r + 1'b1 : least_r + 1'b1;
  assign wr_ovr    = found_r ? hit_ovr_r : least_r;
  assign ram_we    = res_push;
  assign ram_waddr = found_r ? hit_r : victim_r;
  assign ram_wdata = '{key: key_r, count: wr_count, ovr: wr_ovr};

  assign res = '{slot:        ssfc_pkg::SLOT_W'(ram_waddr),
                 matched:     found_r,
                 new_count:   wr_count,
                 error_bound: wr_ovr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      dv_r    <= 1'b0;
      iss_r   <= '0;
      found_r <= 1'b0;
    end else begin
      dv_r <= issue;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            key_r   <= in_key;
            iss_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss_r <= iss_r + 1'b1;
          end
          if (dv_r) begin
            // first match wins
            if (!found_r && hit_now) begin
              found_r   <= 1'b1;
              hit_r     <= didx_r;
              hit_cnt_r <= ent.count;
              hit_ovr_r <= ent.ovr;
            end
            // strict less-than keeps the lowest index on ties
            if (didx_r == '0 || ent.count < least_r) begin
              least_r  <= ent.count;
              victim_r <= didx_r;
            end
            if (didx_r == IW'(NUM_ENTRIES - 1)) begin
              state_r <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          if (res_ready) begin
            vld_r[ram_waddr] <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= iss_r[IW-1:0];
  end

endmodule

[sv/space_saving_flow_counter.sv]
// Channel   Dir  Word
// in_chan   in   5-tuple key: src/dst address, src/dst port, protocol
// out_chan  out  slot, matched flag, new count, error bound
//
// Each word is accepted, the table is read once per entry through the single
// RAM read port, the last read returns, and the updated row is written back.
// rst_n is synchronous; reset clears the per-entry valid flags, so the table
// reads as all zero at once and no clearing sweep is needed.
// A finished result sits in the output register; the next key is taken while
// it waits, and only the write-back stalls if the register is still full.

module space_saving_flow_counter #(
  parameter int NUM_ENTRIES = ssfc_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  ssfc_in_if.sink     in_chan,
  ssfc_out_if.source  out_chan
);

  localparam int IW = $clog2(NUM_ENTRIES);

  logic             res_ready;
  logic             res_push;
  ssfc_pkg::res_t   res;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;
  ssfc_pkg::entry_t ram_wdata;
  ssfc_pkg::entry_t ram_rdata;

  // output register
  logic             out_vld_r;
  ssfc_pkg::res_t   out_r;

  // table: one row per entry, key + count + overestimate
  ssfc_ram #(
    .WIDTH (ssfc_pkg::ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // walks the table: match search and minimum search in one pass
  ssfc_scan #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // free when empty or being drained this cycle
  assign res_ready = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_push) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_r <= res;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.slot        = out_r.slot;
  assign out_chan.matched     = out_r.matched;
  assign out_chan.new_count   = out_r.new_count;
  assign out_chan.error_bound = out_r.error_bound;

endmodule

[tb/tb_space_saving_flow_counter.sv]
`timescale 1ns / 100ps

// Testbench for space_saving_flow_counter.
// A shadow copy of the key table predicts every result word. Keys come from
// a small pool of flows with random content, so matches, evictions and
// near misses all occur. A monitor compares each result word with the oldest
// prediction as a whole word and reports every field on a mismatch.
module tb_space_saving_flow_counter;

  localparam int NUM_ENTRIES = ssfc_pkg::DEF_ENTRIES;
  localparam int POOL_SIZE = 12;      // more flows than entries, so evictions happen
  localparam int LONG_HOLD = 300;     // receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4 * (NUM_ENTRIES + 3);
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  ssfc_in_if  in_chan ();
  ssfc_out_if out_chan ();

  space_saving_flow_counter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow table: key, count and overestimate of each entry.
  ssfc_pkg::key_t               tbl_key   [NUM_ENTRIES];
  logic [ssfc_pkg::COUNT_W-1:0] tbl_count [NUM_ENTRIES];
  logic [ssfc_pkg::COUNT_W-1:0] tbl_ovr   [NUM_ENTRIES];

  ssfc_pkg::res_t expected_updates[$];     // predicted result words, oldest first
  ssfc_pkg::key_t flow_pool[POOL_SIZE];

  // Idling controls, in percent of cycles.
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  // Long hold-off request: the tests bump hold_ask, the receiver counts it out.
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int pkts_accepted = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Space-Saving update of the shadow table for one key. Returns the word the
  // block should emit. Lowest matching index wins; otherwise the entry with
  // the smallest count (lowest index on ties) is overwritten.
  function automatic ssfc_pkg::res_t update_table(input ssfc_pkg::key_t k);
    ssfc_pkg::res_t               r;
    int                           victim;
    logic [ssfc_pkg::COUNT_W-1:0] least;
    bit                           hit;
    hit = 1'b0;
    victim = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!hit && tbl_key[i] == k) begin
        hit = 1'b1;
        victim = i;
      end
    end
    if (hit) begin
      // count wraps at 16 bits, overestimate untouched
      tbl_count[victim] = tbl_count[victim] + 1'b1;
    end else begin
      least = tbl_count[0];
      for (int i = 1; i < NUM_ENTRIES; i++) begin
        if (tbl_count[i] < least) begin
          least = tbl_count[i];
          victim = i;
        end
      end
      tbl_key[victim] = k;
      tbl_ovr[victim] = least;
      tbl_count[victim] = least + 1'b1;
    end
    r.slot = ssfc_pkg::SLOT_W'(victim);
    r.matched = hit;
    r.new_count = tbl_count[victim];
    r.error_bound = tbl_ovr[victim];
    return r;
  endfunction

  // Field values lean on the extremes now and then.
  function automatic logic [31:0] pick_field(input int bits);
    logic [31:0] mask;
    mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic ssfc_pkg::key_t random_key();
    ssfc_pkg::key_t k;
    k.source_address      = pick_field(ssfc_pkg::ADDR_W);
    k.destination_address = pick_field(ssfc_pkg::ADDR_W);
    k.source_port         = ssfc_pkg::PORT_W'(pick_field(ssfc_pkg::PORT_W));
    k.destination_port    = ssfc_pkg::PORT_W'(pick_field(ssfc_pkg::PORT_W));
    k.protocol            = ssfc_pkg::PROTO_W'(pick_field(ssfc_pkg::PROTO_W));
    return k;
  endfunction

  function automatic ssfc_pkg::key_t make_key(input logic [31:0] sa,
                                              input logic [31:0] da,
                                              input logic [15:0] sp,
                                              input logic [15:0] dp,
                                              input logic [7:0] pr);
    ssfc_pkg::key_t k;
    k.source_address = sa;
    k.destination_address = da;
    k.source_port = sp;
    k.destination_port = dp;
    k.protocol = pr;
    return k;
  endfunction

  // Mostly pooled flows (low indices more often, so some become heavy),
  // plus fresh keys, single-bit near misses and the all-zero/all-one keys.
  function automatic ssfc_pkg::key_t next_flow_key();
    int             r;
    int             idx;
    ssfc_pkg::key_t k;
    r = $urandom_range(99);
    idx = $urandom_range(POOL_SIZE - 1);
    if ($urandom_range(1)) idx = $urandom_range(idx);
    if (r < 70) begin
      k = flow_pool[idx];
    end else if (r < 85) begin
      k = random_key();
    end else if (r < 95) begin
      k = flow_pool[idx] ^
          (ssfc_pkg::key_t'(1) << $urandom_range($bits(ssfc_pkg::key_t) - 1));
    end else begin
      k = $urandom_range(1) ? '0 : '1;
    end
    return k;
  endfunction

  // Offer one word, with random idle cycles ahead of it. valid stays high
  // across back-to-back words; it is only lowered when a gap starts.
  task automatic send_key(input ssfc_pkg::key_t k);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid               <= 1'b1;
    in_chan.source_address      <= k.source_address;
    in_chan.destination_address <= k.destination_address;
    in_chan.source_port         <= k.source_port;
    in_chan.destination_port    <= k.destination_port;
    in_chan.protocol            <= k.protocol;
    do @(posedge clk); while (!in_chan.ready);
    expected_updates.push_back(update_table(k));
    pkts_accepted++;
  endtask

  // Sender pause: nothing offered until every predicted word has come back.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
  endtask

  task automatic note_error(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- tests

  // Extremes of each field, the all-zero key matching never-written entries
  // (several hold it, entry 0 must win), a match on a stored key, a near
  // miss, and tie-breaking on equal minimum counts.
  task automatic test_directed();
    ssfc_pkg::key_t ones_minus;
    in_idle_pct = 0;
    out_stall_pct = 0;
    ones_minus = '1;
    ones_minus.protocol = 8'hFE;
    send_key('0);
    send_key('0);
    send_key('1);
    send_key(make_key(32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 8'd0));
    send_key(make_key(32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 8'd0));
    send_key(make_key(32'd0, 32'd0, 16'hFFFF, 16'd0, 8'd0));
    send_key(make_key(32'd0, 32'd0, 16'd0, 16'hFFFF, 8'd0));
    send_key(make_key(32'd0, 32'd0, 16'd0, 16'd0, 8'hFF));
    send_key('1);
    send_key(ones_minus);
    send_key('0);
    // every count is now at least one: ties go to the lowest index
    send_key(make_key(32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd40000, 8'd6));
    send_key(make_key(32'hC0A8_0002, 32'h0A00_0001, 16'd80, 16'd40000, 8'd17));
    send_key(make_key(32'hC0A8_0002, 32'h0A00_0001, 16'd80, 16'd40000, 8'd17));
    send_key(make_key(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80));
    send_key('1);
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // output register fills and the block stops taking input.
  task automatic test_long_hold();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_ask <= hold_ask + 1;
    repeat (24) send_key(next_flow_key());
    wait_for_drain();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) flow_pool[$urandom_range(POOL_SIZE - 1)] = random_key();
      send_key(next_flow_key());
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------- processes

  // Result side: random stalls, plus the long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Result checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin
    ssfc_pkg::res_t got;
    ssfc_pkg::res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.slot = out_chan.slot;
      got.matched = out_chan.matched;
      got.new_count = out_chan.new_count;
      got.error_bound = out_chan.error_bound;
      if (expected_updates.size() == 0) begin
        note_error($sformatf("unexpected word: slot %0d matched %0d count %0d bound %0d",
                             got.slot, got.matched, got.new_count, got.error_bound));
      end else begin
        want = expected_updates.pop_front();
        if (want.matched) begin
          hits_seen++;
        end else begin
          evictions_seen++;
        end
        if (got !== want)
          note_error($sformatf({"mismatch (exp/got): slot %0d/%0d matched %0d/%0d ",
                                "count %0d/%0d bound %0d/%0d"},
                               want.slot, got.slot, want.matched, got.matched,
                               want.new_count, got.new_count,
                               want.error_bound, got.error_bound));
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d words outstanding",
                 quiet_cycles, expected_updates.size());
        $display("space_saving_flow_counter verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.source_address = '0;
    in_chan.destination_address = '0;
    in_chan.source_port = '0;
    in_chan.destination_port = '0;
    in_chan.protocol = '0;
    out_chan.ready = 1'b0;
    // table reads as all zero straight after reset
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_key[i] = '0;
      tbl_count[i] = '0;
      tbl_ovr[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) flow_pool[i] = random_key();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_hold();
    test_random_phase(0, 0, 115);
    test_random_phase(82, 0, 115);
    test_random_phase(0, 82, 115);
    test_random_phase(20, 20, 115);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d packets: %0d matches, %0d evictions",
             pkts_accepted, hits_seen, evictions_seen);
    $display("idle/stall mixes, long result hold-off, drains between phases; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("space_saving_flow_counter verification clean");
    end else begin
      $display("space_saving_flow_counter verification failed");
    end
    $finish;
  end

endmodule

[space_saving_flow_counter.f]
sv/ssfc_pkg.sv
sv/ssfc_if.sv
sv/ssfc_ram.sv
sv/ssfc_scan.sv
sv/space_saving_flow_counter.sv
tb/tb_space_saving_flow_counter.sv
